/* rtl/csr_stable_scatter_cursor_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scatter cursor block
// Shared property forms used by the block's checker; all sample on clk.
// ----------------------------------------------------------------------------
`ifndef CSR_STABLE_SCATTER_CURSOR_TOP_DEFINES_SVH
`define CSR_STABLE_SCATTER_CURSOR_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define CSSC_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cssc check failed");

// Next-cycle implication, off while reset is asserted.
`define CSSC_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cssc check failed");

// Next-cycle implication that also holds across reset.
`define CSSC_CHK_RST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cssc reset check failed");

`endif

/* rtl/cssc_pkg.sv */
// ----------------------------------------------------------------------------
// cssc_pkg
// Types and constants shared by the scatter cursor front, queue and back end.
// ----------------------------------------------------------------------------
package cssc_pkg;

  // Default sizes of the cursor table and of the position arithmetic.
  localparam int RowRangeMaxDef = 4096;
  localparam int IdWidthDef     = 32;

  // Widest table address the row range can ask for (65536 rows).
  localparam int AddrMaxW   = 16;
  localparam int RunW       = 13;
  localparam int QueueDepth = 2;

  // Operation codes of the input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROW_BEGIN = 2'd0;
  localparam logic [1:0] REG_ROW_END   = 2'd1;
  localparam logic [1:0] REG_EMIT_DATA = 2'd2;
  localparam logic [1:0] REG_MAX_RUN   = 2'd3;

  localparam logic [RunW-1:0] MaxRunRst = 13'd1024;

  typedef struct packed {
    logic        operation;
    logic [11:0] slot;
    logic [31:0] base_position;
    logic [31:0] row_id;
    logic [31:0] column;
    logic [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] column_out;
    logic [31:0] value_out;
    logic        starts_run;
  } out_item_t;

  // Configuration as seen by the front and the back end.
  typedef struct packed {
    logic [31:0]     row_begin;
    logic [31:0]     row_end;
    logic            emit_data;
    logic [RunW-1:0] max_run;
  } cfg_t;

  // Classified command handed from the front to the back end.
  typedef struct packed {
    logic                is_edge;
    logic                wr_ok;    // load slot lies inside the table
    logic [AddrMaxW-1:0] addr;
    logic [31:0]         column;
    logic [31:0]         payload;  // load base position, edge value or count
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RMW
  } back_state_t;

endpackage

/* rtl/cssc_front.sv */
// ----------------------------------------------------------------------------
// cssc_front
// Accepts items, counts edges, filters the row band and builds commands.
// ----------------------------------------------------------------------------
module cssc_front #(
  parameter int ROW_RANGE_MAX = cssc_pkg::RowRangeMaxDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cssc_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  cssc_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output cssc_pkg::cmd_t     q_cmd
);
  import cssc_pkg::*;

  localparam logic [31:0] RangeMax = 32'(ROW_RANGE_MAX);

  logic [31:0] edge_cnt_r;
  logic [31:0] edge_cnt_nxt;
  logic [31:0] row_off;
  logic [31:0] slot_ext;
  logic        in_band;
  logic        is_edge;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_edge  = (in_item.operation == OP_EDGE);

  // Band and table range check of the edge's row.
  assign row_off  = in_item.row_id - cfg.row_begin;
  assign slot_ext = 32'(in_item.slot);
  assign in_band  = (in_item.row_id >= cfg.row_begin) && (in_item.row_id < cfg.row_end) &&
                    (row_off < RangeMax);

  // Loads always go to the back end so it can clear run tracking.
  assign q_push = accept && (!is_edge || in_band);

  always_comb begin
    q_cmd.is_edge = is_edge;
    q_cmd.wr_ok   = (slot_ext < RangeMax);
    q_cmd.column  = in_item.column;
    if (is_edge) begin
      q_cmd.addr    = row_off[AddrMaxW-1:0];
      q_cmd.payload = cfg.emit_data ? in_item.data_value : edge_cnt_r;
    end else begin
      q_cmd.addr    = slot_ext[AddrMaxW-1:0];
      q_cmd.payload = in_item.base_position;
    end
  end

  // Every edge advances the counter; a load clears it.
  always_comb begin
    edge_cnt_nxt = edge_cnt_r;
    if (accept) begin
      edge_cnt_nxt = is_edge ? edge_cnt_r + 32'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r <= '0;
    end else begin
      edge_cnt_r <= edge_cnt_nxt;
    end
  end

endmodule

/* rtl/cssc_queue.sv */
// ----------------------------------------------------------------------------
// cssc_queue
// Short command queue that lets the front and back end stall on their own.
// ----------------------------------------------------------------------------
module cssc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cssc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output cssc_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import cssc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW:0] DepthC = (PtrW + 1)'(QueueDepth);

  cmd_t            entry_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW:0]   count_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [PtrW:0]   count_nxt;

  assign full    = (count_r == DepthC);
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/cssc_back.sv */
// ----------------------------------------------------------------------------
// cssc_back
// Cursor table read-modify-write, run tracking and the result register.
// ----------------------------------------------------------------------------
module cssc_back #(
  parameter int ROW_RANGE_MAX = cssc_pkg::RowRangeMaxDef,
  parameter int ID_WIDTH      = cssc_pkg::IdWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cssc_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  cssc_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output cssc_pkg::out_item_t out_item
);
  import cssc_pkg::*;

  localparam int AW = (ROW_RANGE_MAX > 1) ? $clog2(ROW_RANGE_MAX) : 1;

  // Cursor table: one write and one registered read per cycle.
  logic [ID_WIDTH-1:0] mem [ROW_RANGE_MAX];
  logic [ID_WIDTH-1:0] rd_data_r;
  logic                rd_en;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;

  back_state_t         state_r;
  back_state_t         state_nxt;
  logic [AW-1:0]       addr_r;
  logic [31:0]         col_r;
  logic [31:0]         val_r;
  logic [ID_WIDTH-1:0] run_start_r;
  logic [ID_WIDTH-1:0] run_start_nxt;
  logic [RunW-1:0]     run_len_r;
  logic [RunW-1:0]     run_len_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_item_r;
  logic                out_load;

  logic [ID_WIDTH-1:0] pos;
  logic [ID_WIDTH-1:0] run_end;
  logic                run_break;
  logic [RunW-1:0]     len_inc;
  logic [RunW-1:0]     run_cap;
  logic                out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;

  // Run tracking for the picked position.
  assign pos       = rd_data_r;
  assign run_end   = run_start_r + ID_WIDTH'(run_len_r);
  assign run_break = (run_len_r == '0) || (pos != run_end);
  assign len_inc   = run_break ? RunW'(1) : run_len_r + RunW'(1);
  assign run_cap   = (cfg.max_run == '0) ? RunW'(1) : cfg.max_run;

  // Sequencer: a load is written from idle, an edge reads then writes back.
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = q_cmd.addr[AW-1:0];
    mem_wdata     = ID_WIDTH'(q_cmd.payload);
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    out_load      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.is_edge) begin
            rd_en     = 1'b1;
            state_nxt = BK_RMW;
          end else begin
            mem_we        = q_cmd.wr_ok;
            run_start_nxt = '0;
            run_len_nxt   = '0;
          end
        end
      end
      BK_RMW: begin
        if (out_free) begin
          mem_we        = 1'b1;
          mem_waddr     = addr_r;
          mem_wdata     = pos + ID_WIDTH'(1);
          run_start_nxt = run_break ? pos : run_start_r;
          run_len_nxt   = (len_inc >= run_cap) ? '0 : len_inc;
          out_load      = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Result register: holds until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      run_start_r <= '0;
      run_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Edge payload held during the read-modify-write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_r <= q_cmd.addr[AW-1:0];
      col_r  <= q_cmd.column;
      val_r  <= q_cmd.payload;
    end
    if (out_load) begin
      out_item_r.position   <= pos[31:0];
      out_item_r.column_out <= col_r;
      out_item_r.value_out  <= val_r;
      out_item_r.starts_run <= run_break;
    end
  end

  // Cursor table ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[q_cmd.addr[AW-1:0]];
    end
  end

endmodule

/* rtl/csr_stable_scatter_cursor_top.sv */
// ----------------------------------------------------------------------------
// csr_stable_scatter_cursor_top
// Scatter pass of a COO-to-CSR counting sort for one row band.
// ----------------------------------------------------------------------------
//
//   Port group | Direction | Handshake          | Carries
//   in_*       | input     | in_valid/in_ready  | in_item_t (load or edge)
//   out_*      | output    | out_valid/out_ready| out_item_t (one per band edge)
//   cfg_*      | input     | cfg_we             | register index and data
//
// In the back end a load writes its slot straight from idle and an in-band edge
// takes the cursor table's registered read, then the write-back. The front drops
// an out-of-band edge in the cycle it is accepted, after counting it.
// Reset is synchronous and clears control state; the cursor table is not
// cleared and holds nothing meaningful until each slot is loaded.
// A two-entry command queue and a result register let each side stall alone.
// ----------------------------------------------------------------------------
module csr_stable_scatter_cursor_top #(
  parameter int ROW_RANGE_MAX = cssc_pkg::RowRangeMaxDef,
  parameter int ID_WIDTH      = cssc_pkg::IdWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cssc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cssc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import cssc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_push_cmd;
  cmd_t q_pop_cmd;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_BEGIN: cfg_nxt.row_begin = cfg_wdata;
        REG_ROW_END:   cfg_nxt.row_end   = cfg_wdata;
        REG_EMIT_DATA: cfg_nxt.emit_data = cfg_wdata[0];
        REG_MAX_RUN:   cfg_nxt.max_run   = cfg_wdata[RunW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_begin <= '0;
      cfg_r.row_end   <= '0;
      cfg_r.emit_data <= 1'b0;
      cfg_r.max_run   <= MaxRunRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cssc_front #(
    .ROW_RANGE_MAX(ROW_RANGE_MAX)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_push_cmd)
  );

  cssc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (q_pop_cmd),
    .empty   (q_empty)
  );

  cssc_back #(
    .ROW_RANGE_MAX(ROW_RANGE_MAX),
    .ID_WIDTH     (ID_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_cmd    (q_pop_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

/* rtl/cssc_checker.sv */
// ----------------------------------------------------------------------------
// cssc_checker
// Port-level checks of the scatter cursor block, bound to the top level.
// ----------------------------------------------------------------------------
`include "csr_stable_scatter_cursor_top_defines.svh"

module cssc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cssc_pkg::out_item_t out_item
);
  import cssc_pkg::*;

  logic out_take;

  assign out_take = out_valid && out_ready;

  // A stalled result holds its value.
  `CSSC_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // Reset leaves no result pending and the queue open.
  `CSSC_CHK_RST_NEXT(a_rst_idle, !rst_n, !out_valid && in_ready)

  // Back-to-back results inside one run sit at consecutive positions.
  `CSSC_CHK_SAME(a_run_contig,
    out_take && !out_item.starts_run && $past(out_take) && $past(rst_n),
    out_item.position == $past(out_item.position) + 32'd1)

endmodule

bind csr_stable_scatter_cursor_top cssc_checker u_cssc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
